// File: rtl/rotating_end_around_carry_checksum_top_defines.svh
// Assertion macros shared by the checker.
`ifndef ROTATING_END_AROUND_CARRY_CHECKSUM_TOP_DEFINES_SVH
`define ROTATING_END_AROUND_CARRY_CHECKSUM_TOP_DEFINES_SVH

// Checked only outside reset.
`define REARC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define REARC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/rearc_pkg.sv
package rearc_pkg;

  localparam int unsigned WordWidth = 32;
  localparam logic [WordWidth-1:0] TopBit = 32'h8000_0000;
  localparam logic [WordWidth-1:0] CarryZeroSum = 32'd2;

  typedef logic [WordWidth-1:0] word_t;

  typedef struct packed {
    word_t checksum;
    logic  matched;
  } rearc_result_t;

  // Adds a word with end-around carry, then rotates the sum right by one bit.
  function automatic word_t fold_word(input word_t sum, input word_t word);
    logic [WordWidth:0] wide;
    word_t              added;
    wide  = {1'b0, sum} + {1'b0, word};
    added = wide[WordWidth-1:0];
    if (wide[WordWidth]) begin
      if (added == '0) begin
        added = CarryZeroSum;
      end else begin
        added = added + word_t'(1);
      end
    end
    return (added >> 1) | (added[0] ? TopBit : '0);
  endfunction

endpackage

// File: rtl/rearc_acc.sv
module rearc_acc import rearc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  word_t         s_tdata,
  input  logic          s_tlast,
  output logic          res_valid,
  input  logic          res_ready,
  output rearc_result_t res
);

  logic  in_valid;
  word_t in_word;
  logic  in_last;
  word_t running_sum;
  word_t running_sum_next;
  logic  advance;

  assign advance   = in_valid && (!in_last || res_ready);
  assign s_tready  = !in_valid || advance;
  assign res_valid = in_valid && in_last;

  always_comb begin
    res.checksum = ~running_sum;
    res.matched  = (in_word == ~running_sum);
  end

  always_comb begin
    running_sum_next = running_sum;
    if (advance) begin
      if (in_last) begin
        running_sum_next = '0;
      end else begin
        running_sum_next = fold_word(running_sum, in_word);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      running_sum <= '0;
    end else begin
      running_sum <= running_sum_next;
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_word <= s_tdata;
      in_last <= s_tlast;
    end
  end

endmodule

// File: rtl/rearc_out.sv
module rearc_out import rearc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_valid,
  output logic          up_ready,
  input  rearc_result_t up,
  output logic          m_tvalid,
  input  logic          m_tready,
  output word_t         m_tdata,
  output logic          m_tuser
);

  logic          out_valid;
  rearc_result_t out_res;
  logic          skid_valid;
  rearc_result_t skid_res;

  assign up_ready = !skid_valid;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_res.checksum;
  assign m_tuser  = out_res.matched;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || m_tready) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= up_valid;
        end
      end else if (up_valid && !skid_valid) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (up_valid) begin
        out_res <= up;
      end
    end else if (up_valid && !skid_valid) begin
      skid_res <= up;
    end
  end

endmodule

// File: rtl/rotating_end_around_carry_checksum_top.sv
// Rotating end-around-carry checksum over a stream of 32-bit image words.
// Input channel s_axis: tdata carries one image word, tlast marks the final
// word, which holds the stored checksum and is not added to the sum.
// Output channel m_axis: one transfer per final word; tdata is the computed
// checksum (complement of the running sum) and tuser is 1 when the stored
// checksum equals it. Non-final words produce no transfer.
// Path: the result of a final word goes from the input register to the output
// register and m_axis when the output is free. Throughput: one word per cycle
// unless a final word waits on a full skid register, set by the combinational
// add, carry wrap and rotate between the input register and the sum register.
// Reset (rst, synchronous, active high) empties both stages and clears the
// running sum. When the receiver stalls, the result is held in the output
// register and one more result goes into a skid register; words that are
// not final keep flowing into the sum until a final word meets a full output.
module rotating_end_around_carry_checksum_top import rearc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // image_word
  input  logic        s_axis_tlast,   // is_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // computed_checksum
  output logic        m_axis_tuser    // checksum_matches
);

  logic          res_valid;
  logic          res_ready;
  rearc_result_t res;

  rearc_acc u_acc (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_axis_tvalid),
    .s_tready  (s_axis_tready),
    .s_tdata   (s_axis_tdata),
    .s_tlast   (s_axis_tlast),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  rearc_out u_out (
    .clk      (clk),
    .rst      (rst),
    .up_valid (res_valid),
    .up_ready (res_ready),
    .up       (res),
    .m_tvalid (m_axis_tvalid),
    .m_tready (m_axis_tready),
    .m_tdata  (m_axis_tdata),
    .m_tuser  (m_axis_tuser)
  );

endmodule

// File: rtl/rearc_checker.sv
`include "rotating_end_around_carry_checksum_top_defines.svh"

module rearc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  logic [2:0] pending;
  logic       last_in;
  logic       res_out;

  assign last_in = s_axis_tvalid && s_axis_tready && s_axis_tlast;
  assign res_out = m_axis_tvalid && m_axis_tready;

  // Final words taken in whose results have not yet been delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (last_in && !res_out) begin
      pending <= pending + 3'd1;
    end else if (!last_in && res_out) begin
      pending <= pending - 3'd1;
    end
  end

  `REARC_ASSERT(out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "Stalled result changed")
  `REARC_ASSERT_ALWAYS(reset_empty, rst |=> !m_axis_tvalid, "Result shown straight after reset")
  `REARC_ASSERT(no_invented, m_axis_tvalid |-> pending != 3'd0, "Result without a final word")
  `REARC_ASSERT(bounded_fill, pending <= 3'd3, "More results outstanding than storage allows")

endmodule

bind rotating_end_around_carry_checksum_top rearc_checker u_checker (.*);
